// File: rtl/scpa_pkg.sv
// shared constants and types for the size class pool allocator
package scpa_pkg;

  localparam int unsigned PoolGranules  = 4096;
  localparam int unsigned GranuleBytes  = 8;
  localparam int unsigned MaxSmallBytes = 128;
  localparam int unsigned NumClasses    = 16;
  localparam int unsigned DefaultBatch  = 20;
  localparam int unsigned MaxBatch      = 32;
  localparam int unsigned RefillTries   = 4;

  localparam int unsigned AddrW  = $clog2(PoolGranules);
  localparam int unsigned PtrW   = AddrW + 1;
  localparam int unsigned ClassW = $clog2(NumClasses);
  localparam int unsigned SizeW  = 12;
  localparam int unsigned BatchW = 6;
  localparam int unsigned GranW  = ClassW + 1;
  localparam int unsigned ShiftW = $clog2(GranuleBytes);

  typedef logic [1:0] status_t;
  localparam status_t StOk      = 2'd0;
  localparam status_t StZero    = 2'd1;
  localparam status_t StTooBig  = 2'd2;
  localparam status_t StOom     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_WAIT,
    S_REFILL,
    S_THREAD,
    S_SEARCH,
    S_SRCH_WAIT,
    S_FRAG,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [PtrW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } link_req_t;

endpackage

// File: rtl/scpa_link_ram.sv
// next-link memory, one entry per granule, registered read
module scpa_link_ram (
  input  logic                           clk_i,
  input  scpa_pkg::link_req_t            req_i,
  output logic [scpa_pkg::PtrW-1:0]      rdata_o
);

  logic [scpa_pkg::PtrW-1:0] mem [scpa_pkg::PoolGranules];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

// File: rtl/scpa_ctrl.sv
// allocator sequencer: class heads, carve region and list operations
module scpa_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scpa_pkg::BatchW-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_action_i,
  input  logic [scpa_pkg::SizeW-1:0]      in_size_i,
  input  logic [scpa_pkg::AddrW-1:0]      in_addr_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [scpa_pkg::AddrW-1:0]      out_addr_o,
  output scpa_pkg::status_t               out_status_o,
  output scpa_pkg::link_req_t             link_req_o,
  input  logic [scpa_pkg::PtrW-1:0]       link_rdata_i,
  output scpa_pkg::state_e                state_o
);
  localparam int unsigned AW = scpa_pkg::AddrW;
  localparam int unsigned PW = scpa_pkg::PtrW;
  localparam int unsigned CW = scpa_pkg::ClassW;
  localparam int unsigned GW = scpa_pkg::GranW;
  localparam int unsigned NC = scpa_pkg::NumClasses;
  localparam int unsigned SizeW1 = scpa_pkg::SizeW + 1;

  scpa_pkg::state_e state_q, state_d;
  logic [PW-1:0] heads_q [NC];
  logic [PW-1:0] head_wdata;
  logic          head_we;
  logic [CW-1:0] head_widx;
  logic [PW-1:0] cs_q, cs_d, ce_q, ce_d;
  logic [scpa_pkg::BatchW-1:0] batch_q;
  logic [CW-1:0] cls_q, cls_d, k_q, k_d;
  logic [GW-1:0] g_q, g_d;
  logic [5:0]    objs_q, objs_d;
  logic [2:0]    tries_q, tries_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] res_q, res_d;
  scpa_pkg::status_t st_q, st_d;
  logic          ovalid_q, ovalid_d;
  logic [AW-1:0] oaddr_q;
  scpa_pkg::status_t ost_q;

  logic [PW-1:0] left;
  logic [5:0]    nbatch;
  logic [PW-1:0] gsum;
  logic          fits_more;
  logic [PW-1:0] gext;
  logic [SizeW1-1:0] szr;
  logic [SizeW1-1:0] gr_full;

  assign gext   = PW'(g_q);
  assign left   = (ce_q > cs_q) ? (ce_q - cs_q) : '0;
  assign nbatch = (batch_q == '0) ? 6'd1 :
                  (batch_q > 6'(scpa_pkg::MaxBatch)) ? 6'(scpa_pkg::MaxBatch) : batch_q;
  // next carve offset still inside the region and under the batch
  assign gsum      = ptr_q + gext;
  assign fits_more = (gsum + gext <= ce_q) && (objs_q < nbatch);
  assign szr       = SizeW1'(in_size_i) + SizeW1'(scpa_pkg::GranuleBytes - 1);
  assign gr_full   = szr >> scpa_pkg::ShiftW;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == scpa_pkg::S_IDLE);
  assign out_valid_o  = ovalid_q;
  assign out_addr_o   = oaddr_q;
  assign out_status_o = ost_q;
  assign state_o      = state_q;

  always_comb begin
    state_d = state_q; cs_d = cs_q; ce_d = ce_q; cls_d = cls_q; k_d = k_q;
    g_d = g_q; objs_d = objs_q; tries_d = tries_q; ptr_d = ptr_q;
    res_d = res_q; st_d = st_q; ovalid_d = ovalid_q;
    head_we = 1'b0; head_widx = cls_q; head_wdata = '0;
    link_req_o = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      scpa_pkg::S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          g_d   = GW'(gr_full);
          cls_d = CW'(gr_full - 1'b1);
          res_d = '0;
          st_d  = scpa_pkg::StOk;
          if (in_size_i == '0) begin
            st_d = scpa_pkg::StZero; state_d = scpa_pkg::S_DONE;
          end else if ((in_size_i > scpa_pkg::SizeW'(scpa_pkg::MaxSmallBytes)) ||
                       (gr_full > SizeW1'(NC))) begin
            st_d = scpa_pkg::StTooBig; state_d = scpa_pkg::S_DONE;
          end else if (in_action_i) begin
            if ((PW+1)'(in_addr_i) + (PW+1)'(gr_full) >
                (PW+1)'(scpa_pkg::PoolGranules)) begin
              st_d = scpa_pkg::StTooBig;
            end else begin
              link_req_o.we    = 1'b1;
              link_req_o.waddr = in_addr_i;
              link_req_o.wdata = heads_q[CW'(gr_full - 1'b1)];
              head_we    = 1'b1;
              head_widx  = CW'(gr_full - 1'b1);
              head_wdata = PW'(in_addr_i) + 1'b1;
            end
            state_d = scpa_pkg::S_DONE;
          end else begin
            state_d = scpa_pkg::S_POP_RD;
          end
        end
      end
      scpa_pkg::S_POP_RD: begin
        if (heads_q[cls_q] == '0) begin
          tries_d = '0; state_d = scpa_pkg::S_REFILL;
        end else begin
          link_req_o.re    = 1'b1;
          link_req_o.raddr = AW'(heads_q[cls_q] - 1'b1);
          res_d   = AW'(heads_q[cls_q] - 1'b1);
          state_d = scpa_pkg::S_POP_WAIT;
        end
      end
      scpa_pkg::S_POP_WAIT: begin
        head_we = 1'b1; head_widx = cls_q; head_wdata = link_rdata_i;
        state_d = scpa_pkg::S_DONE;
      end
      scpa_pkg::S_REFILL: begin
        if (tries_q == 3'(scpa_pkg::RefillTries)) begin
          st_d = scpa_pkg::StOom; res_d = '0; state_d = scpa_pkg::S_DONE;
        end else if (left >= gext) begin
          res_d  = AW'(cs_q);
          ptr_d  = cs_q;
          objs_d = 6'd1;
          state_d = scpa_pkg::S_THREAD;
        end else begin
          state_d = scpa_pkg::S_FRAG;
        end
      end
      scpa_pkg::S_THREAD: begin
        // ptr_q is the last carved block; carve one more each cycle
        if (fits_more) begin
          if (objs_q == 6'd1) begin
            head_we = 1'b1; head_widx = cls_q; head_wdata = gsum + 1'b1;
          end else begin
            link_req_o.we    = 1'b1;
            link_req_o.waddr = AW'(ptr_q);
            link_req_o.wdata = gsum + 1'b1;
          end
          ptr_d  = gsum;
          objs_d = objs_q + 1'b1;
        end else begin
          if (objs_q > 6'd1) begin
            link_req_o.we    = 1'b1;
            link_req_o.waddr = AW'(ptr_q);
            link_req_o.wdata = '0;
          end
          cs_d    = gsum;
          state_d = scpa_pkg::S_DONE;
        end
      end
      scpa_pkg::S_FRAG: begin
        if (left != '0) begin
          link_req_o.we    = 1'b1;
          link_req_o.waddr = AW'(cs_q);
          link_req_o.wdata = heads_q[CW'(left - 1'b1)];
          head_we    = 1'b1;
          head_widx  = CW'(left - 1'b1);
          head_wdata = cs_q + 1'b1;
        end
        cs_d = ce_q;
        k_d  = cls_q;
        state_d = scpa_pkg::S_SEARCH;
      end
      scpa_pkg::S_SEARCH: begin
        if (heads_q[k_q] != '0) begin
          link_req_o.re    = 1'b1;
          link_req_o.raddr = AW'(heads_q[k_q] - 1'b1);
          ptr_d   = heads_q[k_q] - 1'b1;
          state_d = scpa_pkg::S_SRCH_WAIT;
        end else if (k_q == CW'(NC - 1)) begin
          st_d = scpa_pkg::StOom; res_d = '0; state_d = scpa_pkg::S_DONE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      scpa_pkg::S_SRCH_WAIT: begin
        head_we = 1'b1; head_widx = k_q; head_wdata = link_rdata_i;
        cs_d = ptr_q;
        ce_d = ((PW+1)'(ptr_q) + (PW+1)'(k_q) + 1'b1 > (PW+1)'(scpa_pkg::PoolGranules))
               ? PW'(scpa_pkg::PoolGranules) : PW'(ptr_q + PW'(k_q) + 1'b1);
        tries_d = tries_q + 1'b1;
        state_d = scpa_pkg::S_REFILL;
      end
      scpa_pkg::S_DONE: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1; state_d = scpa_pkg::S_IDLE;
        end
      end
      default: state_d = scpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= scpa_pkg::S_IDLE;
      cs_q     <= '0;
      ce_q     <= PW'(scpa_pkg::PoolGranules);
      batch_q  <= scpa_pkg::BatchW'(scpa_pkg::DefaultBatch);
      ovalid_q <= 1'b0;
      tries_q  <= '0;
      for (int n = 0; n < NC; n++) heads_q[n] <= '0;
    end else begin
      state_q  <= state_d;
      cs_q     <= cs_d;
      ce_q     <= ce_d;
      ovalid_q <= ovalid_d;
      tries_q  <= tries_d;
      if (cfg_valid_i) batch_q <= cfg_data_i;
      if (head_we) heads_q[head_widx] <= head_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d; k_q <= k_d; g_q <= g_d; objs_q <= objs_d;
    ptr_q <= ptr_d; res_q <= res_d; st_q <= st_d;
    // result register, loaded when the result is handed to the output side
    if (state_q == scpa_pkg::S_DONE && !ovalid_q) begin
      oaddr_q <= res_q;
      ost_q   <= st_q;
    end
  end

endmodule

// File: rtl/size_class_pool_allocator.sv
// A free or a rejected request goes from idle straight to the done state; a list pop
// reads the link memory in S_POP_RD and writes the class head in S_POP_WAIT. A refill
// threads one carved block per cycle; a region search scans the class heads upward.
// One transaction is in flight at a time; the result register frees the output side.
// Reset clears the class heads and the carve region; the link memory is not
// cleared and each entry is written before it is read.
module size_class_pool_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // batch_count[5:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // size_bytes[11:0], block_address[23:12]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // result_address[11:0], status[13:12]
);

  scpa_pkg::link_req_t        link_req;
  logic [scpa_pkg::PtrW-1:0]  link_rdata;
  scpa_pkg::state_e           state;
  logic [scpa_pkg::AddrW-1:0] out_addr;
  scpa_pkg::status_t          out_status;

  scpa_link_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  scpa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i[5:0]),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_action_i  (s_axis_tuser),
    .in_size_i    (s_axis_tdata[11:0]),
    .in_addr_i    (s_axis_tdata[23:12]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_status_o (out_status),
    .link_req_o   (link_req),
    .link_rdata_i (link_rdata),
    .state_o      (state)
  );

  assign m_axis_tdata = {2'b00, out_status, out_addr};

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state == scpa_pkg::S_IDLE))
    else $error("input ready outside idle");
  a_one_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transaction accepted");
  a_oom_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_status != scpa_pkg::StOk) |-> (out_addr == '0))
    else $error("nonzero address on failure");
`endif

endmodule

// File: bench/tb.sv
// testbench for the size class pool allocator: random allocate and free traffic with a scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  class alloc_scoreboard;
    logic [12:0] heads[scpa_pkg::NumClasses];
    logic [12:0] links[scpa_pkg::PoolGranules];
    int unsigned cstart, cend, batch;
    logic [11:0] exp_addr[$];
    scpa_pkg::status_t exp_status[$];
    int errors;

    function void clear();
      foreach (heads[i]) heads[i] = 0;
      cstart = 0;
      cend   = scpa_pkg::PoolGranules;
      batch  = scpa_pkg::DefaultBatch;
      errors = 0;
    endfunction

    function void report_mismatch(string what, int exp_v, int got_v);
      $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
      errors++;
    endfunction

    function void push(int unsigned c, int unsigned a);
      if (c >= scpa_pkg::NumClasses || a >= scpa_pkg::PoolGranules) return;
      links[a] = heads[c];
      heads[c] = 13'(a + 1);
    endfunction

    function bit pop(int unsigned c, output int unsigned a);
      int unsigned h;
      if (c >= scpa_pkg::NumClasses) return 0;
      h = heads[c];
      if (h == 0 || h > scpa_pkg::PoolGranules) return 0;
      a = h - 1;
      heads[c] = links[h - 1];
      return 1;
    endfunction

    function bit carve(int unsigned g, int unsigned c, output int unsigned res);
      int unsigned n, left, objs, st, p, e, a;
      bit found;
      n = batch;
      if (n == 0) n = 1;
      if (n > scpa_pkg::MaxBatch) n = scpa_pkg::MaxBatch;
      for (int t = 0; t < scpa_pkg::RefillTries; t++) begin
        left = (cend > cstart) ? cend - cstart : 0;
        if (left >= g) begin
          objs = left / g;
          if (objs > n) objs = n;
          st = cstart;
          cstart += objs * g;
          if (objs > 1) begin
            heads[c] = 13'(st + g + 1);
            for (int i = 1; i < objs; i++) begin
              a = st + i * g;
              if (a < scpa_pkg::PoolGranules) links[a] = (i + 1 < objs) ? 13'(a + g + 1) : 13'd0;
            end
          end
          res = st;
          return 1;
        end
        if (left > 0) push(left - 1, cstart);
        cstart = cend;
        found = 0;
        for (int k = c; k < scpa_pkg::NumClasses; k++) begin
          if (!found && pop(k, p)) begin
            e = p + k + 1;
            if (e > scpa_pkg::PoolGranules) e = scpa_pkg::PoolGranules;
            cstart = p;
            cend = e;
            found = 1;
          end
        end
        if (!found) return 0;
      end
      return 0;
    endfunction

    function void note_request(logic act, logic [11:0] size, logic [11:0] addr);
      int unsigned g, c, res;
      scpa_pkg::status_t st;
      res = 0;
      g = (size + scpa_pkg::GranuleBytes - 1) / scpa_pkg::GranuleBytes;
      c = g - 1;
      if (size == 0) st = scpa_pkg::StZero;
      else if (size > scpa_pkg::MaxSmallBytes || c >= scpa_pkg::NumClasses)
        st = scpa_pkg::StTooBig;
      else st = scpa_pkg::StOk;
      if (st == scpa_pkg::StOk) begin
        if (act == ActFree) begin
          if (addr + g <= scpa_pkg::PoolGranules) push(c, addr);
          else st = scpa_pkg::StTooBig;
        end else if (!pop(c, res)) begin
          if (!carve(g, c, res)) begin
            res = 0;
            st = scpa_pkg::StOom;
          end
        end
      end
      exp_addr.push_back(res[11:0]);
      exp_status.push_back(st);
    endfunction

    function void check_result(logic [15:0] data);
      logic [11:0] ea;
      scpa_pkg::status_t es;
      if (exp_addr.size() == 0) begin
        report_mismatch("result with nothing expected", 0, data);
        return;
      end
      ea = exp_addr.pop_front();
      es = exp_status.pop_front();
      if (data[13:12] !== es) report_mismatch("status", es, data[13:12]);
      if (data[11:0] !== ea) report_mismatch("result_address", ea, data[11:0]);
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;

  alloc_scoreboard sb;
  bit quiet;
  int live_addr[$];
  int live_size[$];

  always #5 clk_i = ~clk_i;

  size_class_pool_allocator uut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (quiet || $urandom_range(0, 3) != 0) m_axis_tready <= 1;
      else begin
        n = $urandom_range(1, 10);
        m_axis_tready <= 0;
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1;
      end
    end
  end

  // valid stays high after an accept until the next transaction or an idle gap
  task automatic send_request(logic act, logic [11:0] size, logic [11:0] addr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {addr, size};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(act, size, addr);
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 0;
  endtask

  task automatic write_batch(logic [5:0] v);
    stop_input();
    while (sb.exp_addr.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i  <= {2'b00, v};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.batch = v;
    cfg_valid_i <= 0;
  endtask

  task automatic alloc_tracked(logic [11:0] size);
    send_request(ActAlloc, size, 12'd0);
    if (sb.exp_status[$] == scpa_pkg::StOk) begin
      live_addr.push_back(sb.exp_addr[$]);
      live_size.push_back(size);
    end
  endtask

  task automatic free_tracked();
    int i;
    logic [11:0] sz;
    i = $urandom_range(0, live_addr.size() - 1);
    sz = 12'(live_size[i]);
    // free with any size of the same class
    sz = 12'(((sz + scpa_pkg::GranuleBytes - 1) / scpa_pkg::GranuleBytes - 1) *
             scpa_pkg::GranuleBytes + $urandom_range(1, scpa_pkg::GranuleBytes));
    send_request(ActFree, sz, 12'(live_addr[i]));
    live_addr.delete(i);
    live_size.delete(i);
  endtask

  task automatic run_phase(int items);
    int r;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) alloc_tracked(12'($urandom_range(1, scpa_pkg::MaxSmallBytes)));
      else if (r < 85 && live_addr.size() > 0) free_tracked();
      else if (r < 90) send_request(1'($urandom_range(0, 1)), 12'd0, 12'($urandom));
      else if (r < 95) send_request(1'($urandom_range(0, 1)),
                                    12'($urandom_range(scpa_pkg::MaxSmallBytes + 1, 4095)),
                                    12'($urandom));
      else send_request(ActFree, 12'($urandom_range(1, scpa_pkg::MaxSmallBytes)),
                        12'($urandom_range(scpa_pkg::PoolGranules - 16,
                                           scpa_pkg::PoolGranules - 1)) | 12'hff0);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    alloc_tracked(12'd1);
    alloc_tracked(12'd8);
    alloc_tracked(12'd9);
    alloc_tracked(12'(scpa_pkg::MaxSmallBytes));
    alloc_tracked(12'd1);
    send_request(ActAlloc, 12'd0, 12'hfff);
    send_request(ActFree, 12'd0, 12'd0);
    send_request(ActAlloc, 12'(scpa_pkg::MaxSmallBytes + 1), 12'd0);
    send_request(ActAlloc, 12'hfff, 12'hfff);
    send_request(ActFree, 12'hfff, 12'hfff);
    send_request(ActFree, 12'(scpa_pkg::MaxSmallBytes), 12'hfff);
    send_request(ActFree, 12'd8, 12'hfff);
    free_tracked();
    free_tracked();
    alloc_tracked(12'd9);
    alloc_tracked(12'd16);

    write_batch(6'd0);
    run_phase(300);
    write_batch(6'd1);
    run_phase(300);
    write_batch(6'd32);
    run_phase(300);
    write_batch(6'd63);
    // exhaust the pool to reach out of memory and region searches
    for (int k = 0; k < 300; k++)
      alloc_tracked(12'($urandom_range(64, scpa_pkg::MaxSmallBytes)));
    while (live_addr.size() > 100) free_tracked();
    write_batch(6'($urandom_range(2, 31)));
    run_phase(300);
    quiet = 1;
    run_phase(250);

    stop_input();
    while (sb.exp_addr.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
